[sv/rbsi_pkg.sv]
// Package for the ray/box slab test: widths, saturation limits, shared types.
// No dependencies.
package rbsi_pkg;

    localparam int WORD_W     = 32;
    localparam int FRAC_BITS  = 16;
    localparam int NUM_REGS   = 6;
    localparam int IDX_W      = 3;
    localparam int NUM_W      = WORD_W + 1 + 24;     // widest numerator
    localparam int DIV_STEPS  = 2;                   // quotient bits per stage

    localparam logic [IDX_W-1:0] REG_MIN_X = 3'd0;
    localparam logic [IDX_W-1:0] REG_MIN_Y = 3'd1;
    localparam logic [IDX_W-1:0] REG_MIN_Z = 3'd2;
    localparam logic [IDX_W-1:0] REG_MAX_X = 3'd3;
    localparam logic [IDX_W-1:0] REG_MAX_Y = 3'd4;
    localparam logic [IDX_W-1:0] REG_MAX_Z = 3'd5;

    localparam logic signed [WORD_W-1:0] T_MAX = 32'sh7fff_ffff;
    localparam logic signed [WORD_W-1:0] T_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [WORD_W-1:0] ray_origin_x;
        logic signed [WORD_W-1:0] ray_origin_y;
        logic signed [WORD_W-1:0] ray_origin_z;
        logic signed [WORD_W-1:0] ray_dir_x;
        logic signed [WORD_W-1:0] ray_dir_y;
        logic signed [WORD_W-1:0] ray_dir_z;
    } ray_t;

    typedef struct packed {
        logic                     hit;
        logic signed [WORD_W-1:0] distance;
    } result_t;

    // per-axis slab result leaving the divider
    typedef struct packed {
        logic                     forced_miss;
        logic signed [WORD_W-1:0] t_near;
        logic signed [WORD_W-1:0] t_far;
    } slab_t;

endpackage

[sv/rbsi_if.sv]
// Valid/ready channel interfaces for rays and results.
// Depends on rbsi_pkg.
interface rbsi_ray_if;
    logic          valid;
    logic          ready;
    rbsi_pkg::ray_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rbsi_res_if;
    logic             valid;
    logic             ready;
    rbsi_pkg::result_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/rbsi_axis.sv]
// One axis of the slab test: pipelined restoring dividers for both bounds,
// then saturation and ordering. Depends on rbsi_pkg.
module rbsi_axis #(
    parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS
) (
    input  logic                                   clk,
    input  logic                                   en,
    input  logic signed [rbsi_pkg::WORD_W-1:0]     lo,
    input  logic signed [rbsi_pkg::WORD_W-1:0]     hi,
    input  logic signed [rbsi_pkg::WORD_W-1:0]     org,
    input  logic signed [rbsi_pkg::WORD_W-1:0]     dir,
    output rbsi_pkg::slab_t                        slab
);
    localparam int W     = rbsi_pkg::WORD_W;
    localparam int NW    = W + 1 + FRAC_BITS;            // magnitude bits of numerator
    localparam int SPS   = rbsi_pkg::DIV_STEPS;
    localparam int NST   = (NW + SPS - 1) / SPS;         // divider stages
    localparam int QW    = NST * SPS;

    typedef struct packed {
        logic [QW-1:0] num;      // numerator shifting out, quotient shifting in
        logic [W:0]    rem;
        logic          neg;
    } div_t;

    typedef struct packed {
        div_t          d1;
        div_t          d2;
        logic [W-1:0]  mag;      // |dir|
        logic          zero;
        logic          below;
        logic          above;
    } ctx_t;

    ctx_t ctx_reg [NST+1];
    ctx_t ctx_next [NST+1];
    ctx_t ctx0_next;

    // stage 0: differences, magnitudes, signs
    logic signed [W:0] diff1, diff2;
    logic [W:0]        mag1, mag2;
    logic              dneg;
    always_comb
    begin
        diff1 = (W+1)'(lo) - (W+1)'(org);
        diff2 = (W+1)'(hi) - (W+1)'(org);
        dneg  = dir[W-1];
        mag1  = diff1[W] ? (W+1)'(-diff1) : diff1;
        mag2  = diff2[W] ? (W+1)'(-diff2) : diff2;
        ctx0_next.d1.num = QW'({mag1, {FRAC_BITS{1'b0}}});
        ctx0_next.d2.num = QW'({mag2, {FRAC_BITS{1'b0}}});
        ctx0_next.d1.rem = '0;
        ctx0_next.d2.rem = '0;
        ctx0_next.d1.neg = diff1[W] ^ dneg;
        ctx0_next.d2.neg = diff2[W] ^ dneg;
        ctx0_next.mag    = dneg ? W'(-dir) : dir;
        ctx0_next.zero   = (dir == '0);
        ctx0_next.below  = org < lo;
        ctx0_next.above  = org > hi;
    end

    // restoring division, SPS bits per stage
    function automatic div_t div_step(div_t d, logic [W-1:0] m);
        logic [W+1:0] trial;
        div_t r;
        r = d;
        for (int s = 0; s < SPS; s++)
        begin
            trial = {r.rem, r.num[QW-1]} - {2'b00, m};
            if (!trial[W+1])
            begin
                r.rem = trial[W:0];
                r.num = {r.num[QW-2:0], 1'b1};
            end
            else
            begin
                r.rem = {r.rem[W-1:0], r.num[QW-1]};
                r.num = {r.num[QW-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    always_comb
    begin
        ctx_next[0] = ctx0_next;
        for (int k = 1; k <= NST; k++)
        begin
            ctx_next[k]    = ctx_reg[k-1];
            ctx_next[k].d1 = div_step(ctx_reg[k-1].d1, ctx_reg[k-1].mag);
            ctx_next[k].d2 = div_step(ctx_reg[k-1].d2, ctx_reg[k-1].mag);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= NST; k++)
                ctx_reg[k] <= ctx_next[k];
        end
    end

    // saturate a signed quotient of magnitude q
    function automatic logic signed [W-1:0] sat(logic [QW-1:0] q, logic neg);
        logic signed [QW:0] v;
        v = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        if (v > $signed((QW+1)'(rbsi_pkg::T_MAX)))
            return rbsi_pkg::T_MAX;
        else if (v < $signed({{(QW+1-W){1'b1}}, rbsi_pkg::T_MIN}))
            return rbsi_pkg::T_MIN;
        else
            return v[W-1:0];
    endfunction

    // final stage: saturate and order, zero-direction cases
    logic signed [W-1:0] t1, t2;
    ctx_t c;
    always_comb
    begin
        c  = ctx_reg[NST];
        t1 = sat(c.d1.num, c.d1.neg);
        t2 = sat(c.d2.num, c.d2.neg);
        slab.forced_miss = 1'b0;
        if (c.zero)
        begin
            if (c.below)
            begin
                slab.t_near = rbsi_pkg::T_MAX;
                slab.t_far  = rbsi_pkg::T_MAX;
                slab.forced_miss = 1'b1;
            end
            else if (c.above)
            begin
                slab.t_near = rbsi_pkg::T_MIN;
                slab.t_far  = rbsi_pkg::T_MIN;
                slab.forced_miss = 1'b1;
            end
            else
            begin
                slab.t_near = rbsi_pkg::T_MIN;
                slab.t_far  = rbsi_pkg::T_MAX;
            end
        end
        else
        begin
            slab.t_near = (t1 < t2) ? t1 : t2;
            slab.t_far  = (t1 < t2) ? t2 : t1;
        end
    end
endmodule

[sv/ray_box_slab_intersection.sv]
// Channel   | Dir | Payload
// ray       | in  | origin x/y/z, direction x/y/z (signed fixed point)
// res       | out | hit, distance
// cfg       | in  | cfg_we, cfg_index, cfg_data: box corners
//
// One ray per cycle unless the output stalls; an accepted ray passes through the
// pipelined dividers (two quotient bits per stage), then the combine and output
// stages, before its result is valid.
// The whole pipeline advances together; a stall at the output freezes it
// only once the last pipeline stage holds a ray, so bubbles are squeezed out.
// Reset clears valid bits and the box registers to zero.
// Depends on rbsi_pkg, rbsi_if, rbsi_axis.
module ray_box_slab_intersection #(
    parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    rbsi_ray_if.sink                             ray,
    rbsi_res_if.source                           res,
    input  logic                                 cfg_we,
    input  logic [rbsi_pkg::IDX_W-1:0]           cfg_index,
    input  logic [rbsi_pkg::WORD_W-1:0]          cfg_data
);
    localparam int W   = rbsi_pkg::WORD_W;
    localparam int NW  = W + 1 + FRAC_BITS;
    localparam int NST = (NW + rbsi_pkg::DIV_STEPS - 1) / rbsi_pkg::DIV_STEPS;
    localparam int LAT = NST + 2;    // axis pipe + combine stage

    logic signed [W-1:0] box_reg [rbsi_pkg::NUM_REGS];

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rbsi_pkg::NUM_REGS; i++)
                box_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rbsi_pkg::REG_MIN_X: box_reg[0] <= cfg_data;
                rbsi_pkg::REG_MIN_Y: box_reg[1] <= cfg_data;
                rbsi_pkg::REG_MIN_Z: box_reg[2] <= cfg_data;
                rbsi_pkg::REG_MAX_X: box_reg[3] <= cfg_data;
                rbsi_pkg::REG_MAX_Y: box_reg[4] <= cfg_data;
                rbsi_pkg::REG_MAX_Z: box_reg[5] <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline advance: last stage empty, or output register empty or being taken
    logic en;
    logic [LAT-1:0] vld_reg;
    logic           out_vld_reg;
    rbsi_pkg::result_t out_reg;

    assign en        = !vld_reg[LAT-1] || !out_vld_reg || res.ready;
    assign ray.ready = en;

    logic signed [W-1:0] org [3];
    logic signed [W-1:0] dir [3];
    assign org[0] = ray.data.ray_origin_x;
    assign org[1] = ray.data.ray_origin_y;
    assign org[2] = ray.data.ray_origin_z;
    assign dir[0] = ray.data.ray_dir_x;
    assign dir[1] = ray.data.ray_dir_y;
    assign dir[2] = ray.data.ray_dir_z;

    rbsi_pkg::slab_t slab [3];
    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        rbsi_axis #(.FRAC_BITS(FRAC_BITS)) u_axis (
            .clk  (clk),
            .en   (en),
            .lo   (box_reg[a]),
            .hi   (box_reg[a+3]),
            .org  (org[a]),
            .dir  (dir[a]),
            .slab (slab[a])
        );
    end

    // combine axes into one registered stage
    logic signed [W-1:0] ent01, ext01, ent_next, ext_next;
    logic                miss_next;
    logic signed [W-1:0] ent_reg, ext_reg;
    logic                miss_reg;
    always_comb
    begin
        ent01    = (slab[1].t_near > slab[0].t_near) ? slab[1].t_near : slab[0].t_near;
        ext01    = (slab[1].t_far  < slab[0].t_far)  ? slab[1].t_far  : slab[0].t_far;
        ent_next = (slab[2].t_near > ent01) ? slab[2].t_near : ent01;
        ext_next = (slab[2].t_far  < ext01) ? slab[2].t_far  : ext01;
        miss_next = slab[0].forced_miss | slab[1].forced_miss | slab[2].forced_miss;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ent_reg  <= ent_next;
            ext_reg  <= ext_next;
            miss_reg <= miss_next;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], ray.valid};
    end

    // output register: load a new beat, or drop the one just taken
    logic hit_c;
    assign hit_c = !miss_reg && !ext_reg[W-1] && (ent_reg <= ext_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en && vld_reg[LAT-1])
            out_vld_reg <= 1'b1;
        else if (res.ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (en && vld_reg[LAT-1])
        begin
            out_reg.hit      <= hit_c;
            out_reg.distance <= hit_c ? ent_reg : ext_reg;
        end
    end

    assign res.valid = out_vld_reg;
    assign res.data  = out_reg;
endmodule
